// ----- design/whbs_pkg.sv -----
// Shared types, constants and widths for the weighted hash bucket select core.
// No dependencies; used by every module of the block.
`default_nettype none

package whbs_pkg;

  localparam int MAX_BEDS    = 6;
  localparam int KEY_W       = 64;
  localparam int WEIGHT_W    = 53;
  localparam int DRAW_W      = 53;
  localparam int SUM_W       = WEIGHT_W + $clog2(MAX_BEDS + 1);
  localparam int BED_W       = 3;
  localparam int REG_IDX_W   = $clog2(MAX_BEDS + 1);
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = REG_IDX_W + 3;
  localparam int OUT_TDATA_W = ((BED_W + 7) / 8) * 8;
  localparam int PFX_STEPS   = $clog2(MAX_BEDS);
  localparam int HASH_STG    = 5;
  localparam int NUM_STG     = HASH_STG + 1;

  localparam logic [KEY_W-1:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [KEY_W-1:0] MIX1   = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX2   = 64'h94d049bb133111eb;
  localparam int SHIFT_A   = 30;
  localparam int SHIFT_B   = 27;
  localparam int SHIFT_C   = 31;
  localparam int DRAW_SHR  = KEY_W - DRAW_W;

  localparam logic [REG_IDX_W-1:0] REG_BED_COUNT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_WEIGHT_BASE = REG_IDX_W'(1);

  localparam logic [BED_W-1:0]    BED_COUNT_RST = BED_W'(2);
  localparam logic [WEIGHT_W-1:0] HALF_SHARE    = WEIGHT_W'(1) << 52;

  typedef logic [KEY_W-1:0]                   key_t;
  typedef logic [DRAW_W-1:0]                  draw_t;
  typedef logic [BED_W-1:0]                   bed_t;
  typedef logic [MAX_BEDS-1:0][WEIGHT_W-1:0]  weight_arr_t;
  typedef logic [MAX_BEDS-1:0][SUM_W-1:0]     sum_arr_t;

  typedef struct packed {
    sum_arr_t            sum;
    logic [MAX_BEDS-1:0] lane_en;
    bed_t                last;
  } cum_t;

  typedef struct packed {
    logic [HASH_STG-1:0] adv;
  } hash_ctl_t;

endpackage

`default_nettype wire

// ----- design/whbs_cfg_regs.sv -----
// APB-style register file: bed count and per-bed weights, with read-back.
// Depends on whbs_pkg.
`default_nettype none

module whbs_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [whbs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [whbs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [whbs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                               cfg_pready,
  output whbs_pkg::bed_t                     bed_count,
  output whbs_pkg::weight_arr_t              weight
);
  import whbs_pkg::*;

  bed_t                 bed_count_r;
  weight_arr_t          weight_r;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx        = cfg_paddr[CFG_ADDR_W-1:3];
  assign bed_count  = bed_count_r;
  assign weight     = weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bed_count_r <= BED_COUNT_RST;
      for (int i = 0; i < MAX_BEDS; i++) begin
        weight_r[i] <= '0;
      end
      weight_r[0] <= HALF_SHARE;
      weight_r[1] <= HALF_SHARE;
    end else if (wr_en) begin
      if (idx == REG_BED_COUNT) begin
        bed_count_r <= cfg_pwdata[BED_W-1:0];
      end
      for (int i = 0; i < MAX_BEDS; i++) begin
        if (idx == REG_IDX_W'(int'(REG_WEIGHT_BASE) + i)) begin
          weight_r[i] <= cfg_pwdata[WEIGHT_W-1:0];
        end
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (idx == REG_BED_COUNT) begin
      cfg_prdata = CFG_DATA_W'(bed_count_r);
    end
    for (int i = 0; i < MAX_BEDS; i++) begin
      if (idx == REG_IDX_W'(int'(REG_WEIGHT_BASE) + i)) begin
        cfg_prdata = CFG_DATA_W'(weight_r[i]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/whbs_prefix.sv -----
// Registered prefix sums of the bed weights (log-depth scan) and the clamped
// bed count decode. Depends on whbs_pkg.
`default_nettype none

module whbs_prefix (
  input  wire logic                  clk,
  input  wire whbs_pkg::bed_t        bed_count,
  input  wire whbs_pkg::weight_arr_t weight,
  output whbs_pkg::cum_t             cum
);
  import whbs_pkg::*;

  sum_arr_t            w_ext;
  sum_arr_t            pfx_r [PFX_STEPS];
  logic [MAX_BEDS-1:0] lane_en_r;
  bed_t                last_r;
  bed_t                n_eff;

  always_comb begin
    for (int i = 0; i < MAX_BEDS; i++) begin
      w_ext[i] = SUM_W'(weight[i]);
    end
  end

  for (genvar s = 0; s < PFX_STEPS; s++) begin : g_step
    sum_arr_t src;
    if (s == 0) begin : g_first
      assign src = w_ext;
    end else begin : g_next
      assign src = pfx_r[s-1];
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < MAX_BEDS; i++) begin
        if (i >= (1 << s)) begin
          pfx_r[s][i] <= src[i] + src[i - (1 << s)];
        end else begin
          pfx_r[s][i] <= src[i];
        end
      end
    end
  end

  always_comb begin
    if (bed_count < BED_W'(2)) begin
      n_eff = BED_W'(2);
    end else if (bed_count > BED_W'(MAX_BEDS)) begin
      n_eff = BED_W'(MAX_BEDS);
    end else begin
      n_eff = bed_count;
    end
  end

  always_ff @(posedge clk) begin
    last_r <= n_eff - BED_W'(1);
    for (int i = 0; i < MAX_BEDS; i++) begin
      lane_en_r[i] <= (BED_W'(i) < n_eff);
    end
  end

  assign cum.sum     = pfx_r[PFX_STEPS-1];
  assign cum.lane_en = lane_en_r;
  assign cum.last    = last_r;

endmodule

`default_nettype wire

// ----- design/whbs_hash.sv -----
// Five-stage pipelined SplitMix64 finaliser producing the 53-bit draw.
// 64x64 products are split into 32x32 partials; depends on whbs_pkg.
`default_nettype none

module whbs_hash (
  input  wire logic                clk,
  input  wire whbs_pkg::hash_ctl_t ctl,
  input  wire whbs_pkg::key_t      key,
  output whbs_pkg::draw_t          draw
);
  import whbs_pkg::*;

  key_t        s1_x_r;
  logic [63:0] s2_ll_r;
  logic [31:0] s2_hl_r;
  logic [31:0] s2_lh_r;
  key_t        s3_x_r;
  logic [63:0] s4_ll_r;
  logic [31:0] s4_hl_r;
  logic [31:0] s4_lh_r;
  draw_t       s5_draw_r;

  key_t s1_sum;
  key_t s1_x_nxt;
  key_t s3_m;
  key_t s3_x_nxt;
  key_t s5_m;
  key_t s5_x;

  assign s1_sum   = key + GOLDEN;
  assign s1_x_nxt = s1_sum ^ (s1_sum >> SHIFT_A);

  assign s3_m     = s2_ll_r + {s2_hl_r + s2_lh_r, 32'h0};
  assign s3_x_nxt = s3_m ^ (s3_m >> SHIFT_B);

  assign s5_m     = s4_ll_r + {s4_hl_r + s4_lh_r, 32'h0};
  assign s5_x     = s5_m ^ (s5_m >> SHIFT_C);

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      s1_x_r <= s1_x_nxt;
    end
    if (ctl.adv[1]) begin
      s2_ll_r <= {32'h0, s1_x_r[31:0]} * {32'h0, MIX1[31:0]};
      s2_hl_r <= s1_x_r[63:32] * MIX1[31:0];
      s2_lh_r <= s1_x_r[31:0] * MIX1[63:32];
    end
    if (ctl.adv[2]) begin
      s3_x_r <= s3_x_nxt;
    end
    if (ctl.adv[3]) begin
      s4_ll_r <= {32'h0, s3_x_r[31:0]} * {32'h0, MIX2[31:0]};
      s4_hl_r <= s3_x_r[63:32] * MIX2[31:0];
      s4_lh_r <= s3_x_r[31:0] * MIX2[63:32];
    end
    if (ctl.adv[4]) begin
      s5_draw_r <= s5_x[KEY_W-1:DRAW_SHR];
    end
  end

  assign draw = s5_draw_r;

endmodule

`default_nettype wire

// ----- design/weighted_hash_bucket_select_core.sv -----
// Top level of the weighted hash bucket select core: stream ports, pipeline
// control and the bed compare stage. Depends on whbs_pkg, whbs_cfg_regs,
// whbs_prefix and whbs_hash.
//
// Each entity key is hashed and routed to one bed; one result per transfer, in
// order. The datapath is a six-stage pipeline (five hash stages, then the
// compare/output register): a new key can be taken every cycle while the
// output side is not stalled. Stalls back up stage by stage, so bubbles are
// squeezed out. Registers (8-byte spacing): 0 bed count, 1..6 weights of beds
// 0..5 in units of 2^-53. Registers are to be written by the user only while the
// pipeline is empty; the block itself does not enforce this.
`default_nettype none

module weighted_hash_bucket_select_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [whbs_pkg::KEY_W-1:0]      in_tdata,   // [63:0] entity_key
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [whbs_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [2:0] bed_sel, [7:3] zero
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [whbs_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [whbs_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [whbs_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                                 cfg_pready
);
  import whbs_pkg::*;

  bed_t                bed_count;
  weight_arr_t         weight;
  cum_t                cum;
  hash_ctl_t           hctl;
  draw_t               draw;

  logic [NUM_STG-1:0]  vld_r;
  logic [NUM_STG-1:0]  rdy;
  bed_t                bed_r;
  bed_t                bed_nxt;
  logic [MAX_BEDS-1:0] hit;

  whbs_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .bed_count  (bed_count),
    .weight     (weight)
  );

  whbs_prefix u_pfx (
    .clk      (clk),
    .bed_count(bed_count),
    .weight   (weight),
    .cum      (cum)
  );

  whbs_hash u_hash (
    .clk (clk),
    .ctl (hctl),
    .key (in_tdata),
    .draw(draw)
  );

  // stage k may load when empty or when the stage after it moves on
  always_comb begin
    rdy[NUM_STG-1] = ~vld_r[NUM_STG-1] | out_tready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
  end

  assign hctl.adv  = rdy[HASH_STG-1:0];
  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NUM_STG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_BEDS; i++) begin
      hit[i] = cum.lane_en[i] & (SUM_W'(draw) < cum.sum[i]);
    end
    bed_nxt = cum.last;
    for (int i = MAX_BEDS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        bed_nxt = BED_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NUM_STG-1]) begin
      bed_r <= bed_nxt;
    end
  end

  assign out_tvalid = vld_r[NUM_STG-1];
  assign out_tdata  = {(OUT_TDATA_W - BED_W)'(0), bed_r};

endmodule

`default_nettype wire

// ----- design/whbs_checker.sv -----
// Port-level checks for the weighted hash bucket select core, bound to the top.
// Depends on whbs_pkg and weighted_hash_bucket_select_core.
`default_nettype none

module whbs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [whbs_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_bed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:3] == 5'd0 && out_tdata[2:0] != 3'd6 &&
                   out_tdata[2:0] != 3'd7)
    else $error("bed index out of range");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with output stage empty");

  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result presented straight after reset");

endmodule

bind weighted_hash_bucket_select_core whbs_checker u_whbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

`default_nettype wire

// ----- test/whbs_route_checker.sv -----
// Scoreboard for the weighted hash bucket select core: mirrors the registers off the
// config port, predicts the bed for every key transfer and checks each result in order.
// Depends on whbs_pkg.
`default_nettype none

module whbs_route_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  input  wire logic                             in_tready,
  input  wire logic [whbs_pkg::KEY_W-1:0]       in_tdata,   // [63:0] entity_key
  input  wire logic                             out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [whbs_pkg::OUT_TDATA_W-1:0] out_tdata,  // [2:0] bed_sel, [7:3] zero
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [whbs_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [whbs_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input  wire logic                             cfg_pready,
  output int                                    fail_count,
  output int                                    pending
);
  import whbs_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [BED_W-1:0]    bed_count_q;
  logic [WEIGHT_W-1:0] share_q [MAX_BEDS];
  bed_t                expected_beds [$];

  function automatic logic [KEY_W-1:0] splitmix(input key_t k);
    logic [KEY_W-1:0] x;
    x = k + GOLDEN;
    x = (x ^ (x >> SHIFT_A)) * MIX1;
    x = (x ^ (x >> SHIFT_B)) * MIX2;
    return x ^ (x >> SHIFT_C);
  endfunction

  function automatic bed_t route_bed(input key_t k);
    logic [KEY_W-1:0] draw;
    logic [KEY_W-1:0] acc;
    int               beds;
    bed_t             pick;
    bit               hit;
    draw = splitmix(k) >> DRAW_SHR;
    beds = int'(bed_count_q);
    if (beds < 2) beds = 2;
    if (beds > MAX_BEDS) beds = MAX_BEDS;
    pick = bed_t'(beds - 1);
    acc  = '0;
    hit  = 1'b0;
    for (int i = 0; i < beds; i++) begin
      acc = acc + share_q[i];
      if (!hit && draw < acc) begin
        pick = bed_t'(i);
        hit  = 1'b1;
      end
    end
    return pick;
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    if (fail_count < MAX_REPORTS)
      $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [REG_IDX_W-1:0] idx;
    bed_t                 want;
    if (!rst_n) begin
      bed_count_q = BED_COUNT_RST;
      foreach (share_q[i]) share_q[i] = '0;
      share_q[0] = HALF_SHARE;
      share_q[1] = HALF_SHARE;
      expected_beds.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_beds = {expected_beds, route_bed(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (expected_beds.size() == 0) begin
          flag_mismatch("unexpected result, bed_sel", -1, int'(out_tdata[BED_W-1:0]));
        end else begin
          want = expected_beds.pop_front();
          if (out_tdata[BED_W-1:0] !== want)
            flag_mismatch("bed_sel", int'(want), int'(out_tdata[BED_W-1:0]));
          if (out_tdata[OUT_TDATA_W-1:BED_W] !== '0)
            flag_mismatch("tdata padding", 0, int'(out_tdata[OUT_TDATA_W-1:BED_W]));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        idx = cfg_paddr[CFG_ADDR_W-1:3];
        if (idx == REG_BED_COUNT)
          bed_count_q = cfg_pwdata[BED_W-1:0];
        else if (idx >= REG_WEIGHT_BASE && int'(idx) < int'(REG_WEIGHT_BASE) + MAX_BEDS)
          share_q[idx - REG_WEIGHT_BASE] = cfg_pwdata[WEIGHT_W-1:0];
      end
    end
    pending = expected_beds.size();
  end

endmodule

`default_nettype wire

// ----- test/tb_weighted_hash_bucket_select_core.sv -----
// Testbench top for the weighted hash bucket select core: clock, reset, key and
// register stimulus with random idling on both streams, and the final verdict.
// Depends on whbs_pkg, weighted_hash_bucket_select_core and whbs_route_checker.
`default_nettype none

module tb_weighted_hash_bucket_select_core;
  import whbs_pkg::*;

  localparam int   LONG_HOLD      = 80;
  localparam int   PHASES         = 12;
  localparam int   KEYS_PER_PHASE = 55;
  localparam logic [REG_IDX_W-1:0] REG_SPARE  = REG_IDX_W'(MAX_BEDS + 1);
  localparam logic [WEIGHT_W-1:0]  FULL_SHARE = '1;
  // hashes to zero, so the draw is zero
  localparam key_t DRAW_ZERO_KEY = ~GOLDEN + key_t'(1);

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  key_t                   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;
  int                     fail_count;
  int                     pending;

  bit                  tx_steady;
  bit                  rx_steady;
  int                  hold_reqs;
  logic [WEIGHT_W-1:0] shares [MAX_BEDS];

  weighted_hash_bucket_select_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  whbs_route_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("** weighted_hash_bucket_select_core: FAILED **");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_share();
    int          r;
    logic [63:0] v;
    r = $urandom_range(0, 99);
    v = rand64();
    if (r < 10) return '0;
    if (r < 15) return FULL_SHARE;
    return v[WEIGHT_W-1:0] >> $urandom_range(1, 4);
  endfunction

  function automatic key_t rand_key();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return DRAW_ZERO_KEY;
    return rand64();
  endfunction

  // entered and left at a falling edge; tvalid stays up when the next key follows at once
  task automatic push_key(input key_t k);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= rand64();
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= k;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  // leaves psel/penable up; bus_release() closes a run of writes
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic bus_release();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper bits carry junk to check the register masks
  task automatic load_config(input logic [BED_W-1:0] count, input bit poke_spare);
    logic [63:0] junk;
    junk = rand64();
    reg_write(REG_BED_COUNT, {junk[63:BED_W], count});
    for (int i = 0; i < MAX_BEDS; i++) begin
      junk = rand64();
      reg_write(REG_IDX_W'(REG_WEIGHT_BASE + i), {junk[63:WEIGHT_W], shares[i]});
    end
    if (poke_spare)
      reg_write(REG_SPARE, '1);
    bus_release();
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (NUM_STG + 2) @(negedge clk);
  endtask

  initial begin : rx_side
    int stall;
    int served;
    stall      = 0;
    served     = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_reqs != served) begin
        served = hold_reqs;
        stall  = LONG_HOLD;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        stall = rx_steady ? 0 : pick_gap();
      end
    end
  end

  initial begin : tx_side
    key_t corner_keys [8];
    corner_keys = '{'0, '1, key_t'(1), {1'b1, 63'b0}, {32{2'b01}}, {32{2'b10}},
                    64'h0123_4567_89ab_cdef, DRAW_ZERO_KEY};
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    hold_reqs   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, extreme keys
    foreach (corner_keys[i]) push_key(corner_keys[i]);
    drain();

    // count below range, bed 0 takes everything short of a full draw
    shares = '{FULL_SHARE, '0, FULL_SHARE, FULL_SHARE, FULL_SHARE, FULL_SHARE};
    load_config(BED_W'(0), 1'b0);
    push_key(DRAW_ZERO_KEY);
    repeat (3) push_key(rand_key());
    drain();

    // count above range, no weight anywhere: fallback to last bed
    shares = '{default: '0};
    load_config(BED_W'(7), 1'b0);
    repeat (3) push_key(rand_key());
    drain();

    // zero-weight bed 0 never chosen
    shares = '{'0, HALF_SHARE, '0, '0, '0, '0};
    load_config(BED_W'(1), 1'b0);
    push_key(DRAW_ZERO_KEY);
    repeat (2) push_key(rand_key());
    drain();

    // even quarters, then a write to an unmapped register
    shares = '{HALF_SHARE >> 1, HALF_SHARE >> 1, HALF_SHARE >> 1, HALF_SHARE >> 1, '0, '0};
    load_config(BED_W'(4), 1'b1);
    push_key(DRAW_ZERO_KEY);
    repeat (3) push_key(rand_key());
    drain();

    for (int p = 0; p < PHASES; p++) begin
      foreach (shares[i]) shares[i] = rand_share();
      load_config(BED_W'($urandom_range(0, 7)), p % 4 == 1);
      if (p == 3) begin
        tx_steady = 1'b1;
        hold_reqs++;
      end
      if (p == 6) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      repeat (KEYS_PER_PHASE) push_key(rand_key());
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      drain();
    end

    if (fail_count == 0 && pending == 0)
      $display("** weighted_hash_bucket_select_core: PASSED **");
    else
      $display("** weighted_hash_bucket_select_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/whbs_pkg.sv
design/whbs_cfg_regs.sv
design/whbs_prefix.sv
design/whbs_hash.sv
design/weighted_hash_bucket_select_core.sv
design/whbs_checker.sv
test/whbs_route_checker.sv
test/tb_weighted_hash_bucket_select_core.sv
